// ===== rtl/bssc_pkg.sv =====
// Shared types, constants and modular add for the bounded step sequence counter.
package bssc_pkg;

    localparam int WAYS_W = 30;
    localparam logic [WAYS_W-1:0] WAYS_MOD = 30'd1000000007;

    typedef logic [WAYS_W-1:0] ways_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_UPDATE,
        ST_DRAIN,
        ST_DONE
    } bssc_state_t;

    // Phase strobes and item flags broadcast to every cell.
    typedef struct packed {
        logic pair_en;
        logic update_en;
        logic shift_en;
        logic is_first;
        logic bad;
    } bssc_ctrl_t;

    // (a + b) mod p for a, b < p.
    function automatic ways_t add_mod(input ways_t a, input ways_t b);
        logic [WAYS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, WAYS_MOD}) begin
            s = s - {1'b0, WAYS_MOD};
        end
        return s[WAYS_W-1:0];
    endfunction

endpackage

// ===== rtl/bssc_cell.sv =====
// One value cell: holds the prefix count for its value and a drain-chain stage.
module bssc_cell
    import bssc_pkg::*;
#(
    parameter int CMP_W = 8,
    parameter int VALUE = 1
) (
    input  logic             aclk,
    input  bssc_ctrl_t       ctrl,
    input  logic [7:0]       fixed,
    input  logic [CMP_W-1:0] max_eff,
    input  ways_t            left_ways,
    input  ways_t            right_ways,
    input  ways_t            shift_in,
    output ways_t            ways,
    output ways_t            shift_out
);

    localparam logic [CMP_W-1:0] CELL_V = CMP_W'(VALUE);

    ways_t table_reg, table_next;
    ways_t pair_reg, pair_next;
    ways_t shadow_reg, shadow_next;
    ways_t right_eff;
    ways_t sum;
    logic  allowed;

    always_comb begin
        allowed   = !ctrl.bad && (CELL_V <= max_eff)
                    && ((fixed == 8'd0) || (CMP_W'(fixed) == CELL_V));
        // the upper neighbor only counts while it is inside the range
        right_eff = (CELL_V < max_eff) ? right_ways : '0;
        sum       = add_mod(pair_reg, right_eff);

        pair_next   = ctrl.pair_en ? add_mod(table_reg, left_ways) : pair_reg;
        table_next  = table_reg;
        shadow_next = shadow_reg;
        if (ctrl.update_en) begin
            if (!allowed) begin
                table_next = '0;
            end else if (ctrl.is_first) begin
                table_next = ways_t'(1);
            end else begin
                table_next = sum;
            end
            shadow_next = table_next;
        end else if (ctrl.shift_en) begin
            shadow_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        table_reg  <= table_next;
        pair_reg   <= pair_next;
        shadow_reg <= shadow_next;
    end

    assign ways      = table_reg;
    assign shift_out = shadow_reg;

endmodule

// ===== rtl/bounded_step_sequence_counter_top.sv =====
// Top level of the bounded step sequence counter: control, cell row, drain and output.
//
//  channel | ports              | beat contents (low bit up)
//  --------+--------------------+----------------------------------------
//  input   | s_tvalid/s_tready  | tdata: value[7:0]; tuser: first
//  result  | m_tvalid/m_tready  | tdata: ways[29:0], 2'b0; tuser: bad_value
//  config  | cfg_wr_en          | cfg_wr_data: max_value[7:0]
//
// Each item runs through accept, a two-step cell update (neighbor pair sum,
// then add of the upper neighbor), a drain that shifts the row's counts into
// the modular accumulator, and a load of the output register.
// Reset clears control state, the started flag and max_value (to 128).
// A stalled result holds the output register; the next beat is still taken,
// and the block waits at the end of its drain until the register frees.
module bounded_step_sequence_counter_top
    import bssc_pkg::*;
#(
    parameter int VALUE_RANGE = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // value[7:0]
    input  logic [0:0]  s_tuser,   // first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // ways[29:0], zero pad[31:30]
    output logic [0:0]  m_tuser,   // bad_value
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int VW    = $clog2(VALUE_RANGE + 1);
    localparam int CMP_W = (VW > 8) ? VW : 8;
    localparam int CW    = $clog2(VALUE_RANGE);

    bssc_state_t state_reg, state_next;

    logic [7:0]       max_value_reg;
    logic             started_reg;
    logic [7:0]       fixed_reg;
    logic             first_reg;
    logic             bad_reg;
    logic [CMP_W-1:0] max_eff_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    ways_t            acc_reg, acc_next;
    logic             m_tvalid_reg, m_tvalid_next;
    ways_t            m_ways_reg;
    logic             m_bad_reg;

    logic             s_accept;
    logic             out_load;
    logic [CMP_W-1:0] max_sat;
    logic             bad_in;
    bssc_ctrl_t       ctrl;

    ways_t cell_ways  [VALUE_RANGE];
    ways_t cell_shift [VALUE_RANGE];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        max_sat = (CMP_W'(max_value_reg) > CMP_W'(VALUE_RANGE))
                  ? CMP_W'(VALUE_RANGE) : CMP_W'(max_value_reg);
        bad_in  = (s_tdata != 8'd0) && (CMP_W'(s_tdata) > max_sat);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_PAIR;
            ST_PAIR:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_DRAIN;
            ST_DRAIN:  if (cnt_reg == '0) state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        ctrl.pair_en   = (state_reg == ST_PAIR);
        ctrl.update_en = (state_reg == ST_UPDATE);
        ctrl.shift_en  = (state_reg == ST_DRAIN);
        ctrl.is_first  = first_reg;
        ctrl.bad       = bad_reg;

        cnt_next = cnt_reg;
        acc_next = acc_reg;
        case (state_reg)
            ST_UPDATE: begin
                cnt_next = CW'(VALUE_RANGE - 1);
                acc_next = '0;
            end
            ST_DRAIN: begin
                cnt_next = cnt_reg - CW'(1);
                acc_next = add_mod(acc_reg, cell_shift[0]);
            end
            default: ;
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_value_reg <= 8'd128;
            started_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                max_value_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                started_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        if (s_accept) begin
            fixed_reg   <= s_tdata;
            first_reg   <= s_tuser[0] || !started_reg;
            bad_reg     <= bad_in;
            max_eff_reg <= max_sat;
        end
        if (out_load) begin
            m_ways_reg <= acc_reg;
            m_bad_reg  <= bad_reg;
        end
    end

    for (genvar i = 0; i < VALUE_RANGE; i++) begin : g_cell
        ways_t left_w, right_w, shin_w;
        if (i == 0) begin : g_lo
            assign left_w = '0;
        end else begin : g_lo
            assign left_w = cell_ways[i-1];
        end
        if (i == VALUE_RANGE - 1) begin : g_hi
            assign right_w = '0;
            assign shin_w  = '0;
        end else begin : g_hi
            assign right_w = cell_ways[i+1];
            assign shin_w  = cell_shift[i+1];
        end

        bssc_cell #(
            .CMP_W (CMP_W),
            .VALUE (i + 1)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .fixed      (fixed_reg),
            .max_eff    (max_eff_reg),
            .left_ways  (left_w),
            .right_ways (right_w),
            .shift_in   (shin_w),
            .ways       (cell_ways[i]),
            .shift_out  (cell_shift[i])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_ways_reg};
    assign m_tuser  = m_bad_reg;

    a_accept_to_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_PAIR))
        else $error("accepted beat did not start the cell update");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[29:0] == '0))
        else $error("out-of-range value gave nonzero ways");

    a_ways_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:0] < WAYS_MOD))
        else $error("ways not reduced modulo the prime");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared before the drain finished");

endmodule

// ===== tb/bounded_step_sequence_counter_top_test.sv =====
// Self-checking testbench for the bounded step sequence counter: directed and random arrays.
module bounded_step_sequence_counter_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bssc_pkg::*;

    localparam int VALUE_RANGE = 128;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam longint unsigned WAYS_P = WAYS_MOD;

    typedef struct packed {
        ways_t ways;
        logic  bad_value;
    } prefix_count_t;

    // Tracks the per-value prefix counts and queues the count each element should produce.
    class ways_checker;
        ways_t         prefix_ways [VALUE_RANGE];
        bit            started;
        logic [7:0]    max_value;
        prefix_count_t expected_counts [$];
        int            mismatches;
        int            checked;

        function new();
            foreach (prefix_ways[i]) prefix_ways[i] = '0;
            started    = 1'b0;
            max_value  = 8'd128;
            mismatches = 0;
            checked    = 0;
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            mismatches++;
        endtask

        function void set_max(logic [7:0] v);
            max_value = v;
        endfunction

        function int value_limit();
            return (max_value > VALUE_RANGE) ? VALUE_RANGE : int'(max_value);
        endfunction

        function void note_element(logic [7:0] fixed, logic first_in);
            ways_t           next_ways [VALUE_RANGE];
            longint unsigned total;
            longint unsigned s;
            int              lim;
            bit              is_first;
            bit              bad;
            bit              allowed;
            prefix_count_t   want;
            is_first = first_in || !started;
            lim      = value_limit();
            bad      = (fixed != 8'd0) && (int'(fixed) > lim);
            total    = 0;
            for (int v = 1; v <= VALUE_RANGE; v++) begin
                next_ways[v-1] = '0;
                allowed = !bad && (v <= lim) && (fixed == 8'd0 || int'(fixed) == v);
                if (allowed) begin
                    if (is_first) begin
                        next_ways[v-1] = ways_t'(1);
                    end else begin
                        s = prefix_ways[v-1];
                        if (v > 1) s += prefix_ways[v-2];
                        // cells above the limit are dead and never feed a neighbor
                        if (v < lim) s += prefix_ways[v];
                        next_ways[v-1] = ways_t'(s % WAYS_P);
                    end
                end
                total += next_ways[v-1];
            end
            prefix_ways    = next_ways;
            started        = 1'b1;
            want.ways      = ways_t'(total % WAYS_P);
            want.bad_value = bad;
            expected_counts.push_back(want);
        endfunction

        task check_count(logic [31:0] data, logic [0:0] flag);
            prefix_count_t want;
            checked++;
            if (expected_counts.size() == 0) begin
                report($sformatf("count beat %h/%b with nothing pending", data, flag));
                return;
            end
            want = expected_counts.pop_front();
            if (data[WAYS_W-1:0] !== want.ways)
                report($sformatf("beat %0d ways %0d, want %0d",
                                 checked, data[WAYS_W-1:0], want.ways));
            if (data[31:WAYS_W] !== '0)
                report($sformatf("beat %0d pad bits %b", checked, data[31:WAYS_W]));
            if (flag[0] !== want.bad_value)
                report($sformatf("beat %0d bad_value %b, want %b",
                                 checked, flag[0], want.bad_value));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    ways_checker counter;
    bit          tx_idle;
    bit          rx_idle;
    int          cycle_count;
    int          elements_sent;
    int          arrays_sent;
    int          settings_used;

    bounded_step_sequence_counter_top #(
        .VALUE_RANGE (VALUE_RANGE)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stall bursts when enabled
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) counter.check_count(m_tdata, m_tuser);
    end

    task automatic send_element(input logic [7:0] v, input logic f);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= f;
        do @(posedge aclk); while (!s_tready);
        counter.note_element(v, f);
        elements_sent++;
    endtask

    task automatic drain_counts();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (counter.expected_counts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max(input logic [7:0] v);
        drain_counts();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        counter.set_max(v);
        settings_used++;
    endtask

    // Mostly free entries and fixed values within one step of the last one, so counts stay live.
    task automatic send_array(input int len);
        int         lim;
        int         r;
        int         step;
        logic [7:0] v;
        logic [7:0] prev;
        logic       f;
        lim  = counter.value_limit();
        prev = 8'd0;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                v = 8'd0;
            end else if (r < 85 && lim > 0) begin
                if (prev != 8'd0) begin
                    step = int'(prev) + int'($urandom_range(0, 2)) - 1;
                    if (step < 1) step = 1;
                    if (step > lim) step = lim;
                    v = 8'(step);
                end else begin
                    v = 8'($urandom_range(1, lim));
                end
            end else begin
                v = 8'($urandom_range(0, 255));
            end
            f = (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0);
            send_element(v, f);
            if (v != 8'd0) prev = v;
        end
        arrays_sent++;
    endtask

    initial begin : main
        logic [7:0] phase_max [12];
        int         phase_items;
        int         phase_start;
        counter     = new();
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        aresetn     = 1'b0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // reset maximum, continuation before any start, out-of-range fixed values
        send_element(8'd0, 1'b0);
        send_element(8'd0, 1'b0);
        send_element(8'd128, 1'b0);
        send_element(8'd255, 1'b0);
        send_element(8'd0, 1'b0);
        send_element(8'd1, 1'b1);
        send_element(8'd2, 1'b0);
        send_element(8'd129, 1'b1);
        // zero maximum: nothing allowed
        write_max(8'd0);
        send_element(8'd0, 1'b1);
        send_element(8'd7, 1'b0);
        // maximum saturates to the value range
        write_max(8'd255);
        send_element(8'd0, 1'b1);
        send_element(8'd128, 1'b0);
        send_element(8'd129, 1'b0);
        write_max(8'd1);
        send_element(8'd0, 1'b1);
        send_element(8'd0, 1'b0);
        send_element(8'd1, 1'b0);
        send_element(8'd2, 1'b0);
        // maximum lowered in the middle of an array
        write_max(8'd128);
        send_element(8'd0, 1'b1);
        send_element(8'd0, 1'b0);
        send_element(8'd64, 1'b0);
        write_max(8'd2);
        send_element(8'd0, 1'b0);
        send_element(8'd0, 1'b0);

        phase_max = '{8'd128, 8'd1, 8'd2, 8'd0, 8'd255, 8'd129, 8'd64, 8'd3,
                      8'd127, 8'($urandom_range(1, 128)), 8'd200, 8'($urandom_range(1, 128))};
        foreach (phase_max[p]) begin
            write_max(phase_max[p]);
            tx_idle = (p == 11) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle = (p == 11) ? 1'b0 : ($urandom_range(0, 3) != 0);
            phase_start = elements_sent;
            phase_items = 0;
            while (phase_items < 70) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_array($urandom_range(13, 40));
                end else begin
                    send_array($urandom_range(1, 12));
                end
                phase_items = elements_sent - phase_start;
                if (phase_items >= 30 && phase_items < 45) drain_counts();
            end
        end

        drain_counts();
        repeat (VALUE_RANGE + 8) @(posedge aclk);
        $display("tb: %0d elements in %0d random arrays plus directed cases, %0d counts checked",
                 elements_sent, arrays_sent, counter.checked);
        $display("tb: %0d max_value writes, including zero, one, the range limit and saturation",
                 settings_used);
        if (counter.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
